FILE: design/utf8v_pkg.sv
// Shared types, constants and byte-classification functions for the UTF-8
// start and line counter. No dependencies.
`timescale 1ns / 1ps

package utf8v_pkg;

    // Running counter width and width of each result field
    localparam int COUNT_WIDTH = 40;
    localparam int OUT_WIDTH   = 40;
    localparam int WIN_DEPTH   = 3;

    // Byte codes and bounds
    localparam logic [7:0] NEWLINE   = 8'h0A;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] ASCII_TOP = 8'h80;
    localparam logic [7:0] TWO_LO    = 8'hC2;
    localparam logic [7:0] TWO_HI    = 8'hDF;
    localparam logic [7:0] THREE_LO  = 8'hE0;
    localparam logic [7:0] THREE_HI  = 8'hEF;
    localparam logic [7:0] THREE_SUR = 8'hED;
    localparam logic [7:0] FOUR_LO   = 8'hF0;
    localparam logic [7:0] FOUR_HI   = 8'hF4;
    localparam logic [7:0] SEC_LO    = 8'h80;
    localparam logic [7:0] SEC_HI    = 8'hBF;
    localparam logic [7:0] E0_SEC_LO = 8'hA0;
    localparam logic [7:0] ED_SEC_HI = 8'h9F;
    localparam logic [7:0] F0_SEC_LO = 8'h90;
    localparam logic [7:0] F4_SEC_HI = 8'h8F;

    // One accepted input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_item;

    // Window contents with the new byte placed after the held ones
    typedef logic [3:0][7:0] t_lanes;

    // Classifier result handed to the counter stage
    typedef struct packed {
        t_lanes     lanes;
        logic [2:0] starts;
    } t_class;

    // A present byte of the form 10xxxxxx
    function automatic logic is_cont(input logic [7:0] b, input logic present);
        is_cont = present && ((b & CONT_MASK) == CONT_TAG);
    endfunction

    // Does v start a well-formed sequence, given the following bytes?
    function automatic logic valid_start(
        input logic [7:0] v,
        input logic [7:0] s, input logic s_ok,
        input logic [7:0] t, input logic t_ok,
        input logic [7:0] u, input logic u_ok
    );
        logic [7:0] lo;
        logic [7:0] hi;
        logic       res;
        lo  = SEC_LO;
        hi  = SEC_HI;
        res = 1'b0;
        if (v < ASCII_TOP) begin
            res = 1'b1;
        end else if (v >= TWO_LO && v <= TWO_HI) begin
            res = is_cont(s, s_ok);
        end else if (!s_ok) begin
            res = 1'b0;
        end else if (v >= THREE_LO && v <= THREE_HI) begin
            lo  = (v == THREE_LO)  ? E0_SEC_LO : SEC_LO;
            hi  = (v == THREE_SUR) ? ED_SEC_HI : SEC_HI;
            res = (s >= lo) && (s <= hi) && is_cont(t, t_ok);
        end else if (v >= FOUR_LO && v <= FOUR_HI) begin
            lo  = (v == FOUR_LO) ? F0_SEC_LO : SEC_LO;
            hi  = (v == FOUR_HI) ? F4_SEC_HI : SEC_HI;
            res = (s >= lo) && (s <= hi) && is_cont(t, t_ok) && is_cont(u, u_ok);
        end
        valid_start = res;
    endfunction

endpackage

FILE: design/utf8v_classify.sv
// Combinational classifier: places the new byte behind the window and counts
// well-formed sequence starts to retire. Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_classify (
    input  logic [2:0][7:0]     i_window,
    input  logic [1:0]          i_fill,
    input  utf8v_pkg::t_item    i_item,
    output utf8v_pkg::t_class   o_class
);

    utf8v_pkg::t_lanes lanes;
    logic [2:0]        avail;
    logic [3:0]        present;
    logic [3:0]        start_ok;
    logic [2:0]        sum_final;

    // Build the four-byte view; positions past the new byte are missing
    always_comb begin
        avail = {1'b0, i_fill} + 3'd1;
        for (int i = 0; i < 4; i++) begin
            present[i] = (3'(i) < avail);
            if (3'(i) < {1'b0, i_fill}) begin
                lanes[i] = i_window[i[1:0]];
            end else if (3'(i) == {1'b0, i_fill}) begin
                lanes[i] = i_item.data_byte;
            end else begin
                lanes[i] = 8'h00;
            end
        end
    end

    // Check each position against the bytes that follow it
    always_comb begin
        start_ok[0] = utf8v_pkg::valid_start(lanes[0], lanes[1], present[1],
                                             lanes[2], present[2], lanes[3], present[3]);
        start_ok[1] = utf8v_pkg::valid_start(lanes[1], lanes[2], present[2],
                                             lanes[3], present[3], 8'h00, 1'b0);
        start_ok[2] = utf8v_pkg::valid_start(lanes[2], lanes[3], present[3],
                                             8'h00, 1'b0, 8'h00, 1'b0);
        start_ok[3] = utf8v_pkg::valid_start(lanes[3], 8'h00, 1'b0,
                                             8'h00, 1'b0, 8'h00, 1'b0);
    end

    // Final byte retires every held position; otherwise only the oldest when full
    always_comb begin
        sum_final = 3'd0;
        for (int i = 0; i < 4; i++) begin
            sum_final = sum_final + {2'b00, start_ok[i] & present[i]};
        end
        o_class.lanes = lanes;
        if (i_item.final_byte) begin
            o_class.starts = sum_final;
        end else if (i_fill == 2'd3) begin
            o_class.starts = {2'b00, start_ok[0]};
        end else begin
            o_class.starts = 3'd0;
        end
    end

endmodule

FILE: design/utf8v_core.sv
// Window, saturating counters and result register of the UTF-8 counter.
// Depends on utf8v_pkg and utf8v_classify.
`timescale 1ns / 1ps

module utf8v_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  utf8v_pkg::t_item     i_item,
    output logic                 o_take,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [utf8v_pkg::OUT_WIDTH-1:0] o_chars,
    output logic [utf8v_pkg::OUT_WIDTH-1:0] o_lines
);

    localparam int CW = utf8v_pkg::COUNT_WIDTH;
    localparam int OW = utf8v_pkg::OUT_WIDTH;

    logic [2:0][7:0]      r_window, n_window;
    logic [1:0]           r_fill, n_fill;
    logic [CW-1:0]        r_chars, n_chars;
    logic [CW-1:0]        r_lines, n_lines;
    logic                 r_out_valid, n_out_valid;
    logic [OW-1:0]        r_out_chars, n_out_chars;
    logic [OW-1:0]        r_out_lines, n_out_lines;
    utf8v_pkg::t_class    cls;
    logic [CW:0]          char_sum;
    logic [CW:0]          line_sum;
    logic [CW-1:0]        char_sat;
    logic [CW-1:0]        line_sat;

    utf8v_classify u_classify (
        .i_window (r_window),
        .i_fill   (r_fill),
        .i_item   (i_item),
        .o_class  (cls)
    );

    // A final byte waits only while an earlier result is still unread
    assign o_take = i_valid && (!i_item.final_byte || !r_out_valid || i_out_ready);

    // Saturating adds; the maximum is all ones, so the carry marks overflow
    always_comb begin
        char_sum = {1'b0, r_chars} + (CW + 1)'(cls.starts);
        line_sum = {1'b0, r_lines} +
                   (CW + 1)'(i_item.data_byte == utf8v_pkg::NEWLINE);
        char_sat = char_sum[CW] ? {CW{1'b1}} : char_sum[CW-1:0];
        line_sat = line_sum[CW] ? {CW{1'b1}} : line_sum[CW-1:0];
    end

    // Next state of window, counters and result
    always_comb begin
        n_window    = r_window;
        n_fill      = r_fill;
        n_chars     = r_chars;
        n_lines     = r_lines;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_chars = r_out_chars;
        n_out_lines = r_out_lines;
        if (o_take) begin
            if (i_item.final_byte) begin
                n_window    = '0;
                n_fill      = 2'd0;
                n_chars     = '0;
                n_lines     = '0;
                n_out_valid = 1'b1;
                n_out_chars = OW'(char_sat);
                n_out_lines = OW'(line_sat);
            end else begin
                n_chars = char_sat;
                n_lines = line_sat;
                if (r_fill == 2'd3) begin
                    n_window = {cls.lanes[3], cls.lanes[2], cls.lanes[1]};
                end else begin
                    n_window = {cls.lanes[2], cls.lanes[1], cls.lanes[0]};
                    n_fill   = r_fill + 2'd1;
                end
            end
        end
    end

    // Control state resets; result payload does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_fill      <= 2'd0;
            r_chars     <= '0;
            r_lines     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_window    <= n_window;
            r_fill      <= n_fill;
            r_chars     <= n_chars;
            r_lines     <= n_lines;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_chars <= n_out_chars;
        r_out_lines <= n_out_lines;
    end

    assign o_out_valid = r_out_valid;
    assign o_chars     = r_out_chars;
    assign o_lines     = r_out_lines;

`ifndef NO_ASSERTIONS
    // A final byte leaves an empty window and cleared counters
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.final_byte) |=> (r_fill == 2'd0 && r_chars == '0))
        else $error("window or counter not cleared after final byte");

    // A held byte that is not final never waits
    a_no_stall_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_take) |-> (i_item.final_byte && r_out_valid && !i_out_ready))
        else $error("stage stalled without a pending result");

    // Character count never goes down within a stream
    a_chars_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_item.final_byte) |=> (r_chars >= $past(r_chars)))
        else $error("character count decreased mid-stream");

    // Window grows by one byte until full
    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_item.final_byte && r_fill != 2'd3)
        |=> (r_fill == $past(r_fill) + 2'd1))
        else $error("window fill did not advance");
`endif

endmodule

FILE: design/utf8_valid_start_and_line_counter.sv
// Top level of the UTF-8 sequence-start and newline counter: input register
// plus counter core. Depends on utf8v_pkg and utf8v_core.
`timescale 1ns / 1ps

// Takes one text byte per clock on the slave stream, tlast marking the last
// byte of a stream. Each byte is first registered, then classified against a
// three-byte lookahead window and added to 40-bit saturating totals of
// well-formed UTF-8 sequence starts and of newline bytes. The transfer that
// carries tlast yields, through the input register and the result register,
// one result on the master stream with both totals, and the counters start
// again from zero. Sustained rate is one byte per cycle; the only stall is a
// final byte reaching the counter stage while the previous result still sits
// unread in the output register. No clearing pass is needed after reset.
module utf8_valid_start_and_line_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [39:0] char_count, [79:40] line_count
);

    logic                r_in_valid, n_in_valid;
    utf8v_pkg::t_item    r_in_item, n_in_item;
    logic                take;
    logic [utf8v_pkg::OUT_WIDTH-1:0] chars;
    logic [utf8v_pkg::OUT_WIDTH-1:0] lines;

    // Input register refills in the same cycle the core takes its byte
    assign s_axis_tready = !r_in_valid || take;

    always_comb begin
        n_in_valid = r_in_valid && !take;
        n_in_item  = r_in_item;
        if (s_axis_tvalid && s_axis_tready) begin
            n_in_valid           = 1'b1;
            n_in_item.data_byte  = s_axis_tdata;
            n_in_item.final_byte = s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_item <= n_in_item;
    end

    utf8v_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_item      (r_in_item),
        .o_take      (take),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_chars     (chars),
        .o_lines     (lines)
    );

    assign m_axis_tdata = {lines, chars};

endmodule
